FILE: design/mbs_pkg.sv
package mbs_pkg;

  localparam logic [7:0] FC_READ_HOLD  = 8'h03;
  localparam logic [7:0] FC_READ_INPUT = 8'h04;
  localparam logic [7:0] FC_WRITE_ONE  = 8'h06;
  localparam logic [7:0] FC_WRITE_MANY = 8'h10;

  localparam logic [7:0] EXC_ADDRESS = 8'h02;
  localparam logic [7:0] EXC_VALUE   = 8'h03;

  localparam logic [7:0] UNKNOWN_LEN = 8'hff;

  localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_BASE_ADDRESS   = 2'd1;
  localparam logic [1:0] CFG_WINDOW_SIZE    = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd3;

  // handoff from the frame collector to the executor
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] fc;
    logic [15:0] start;
    logic [15:0] count;
    logic [7:0] byte_count;
  } frame_hdr_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ 16'hA001;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

FILE: design/mbs_front.sv
module mbs_front #(
  parameter int FRAME_BYTES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic command,
  input  logic [7:0] rx_byte,
  input  logic [7:0] device_address,
  input  logic [15:0] timeout_ticks,
  // frame handoff
  output logic hdr_valid,
  input  logic hdr_ready,
  output mbs_pkg::frame_hdr_t hdr,
  // payload bytes of a 0x10 frame, read by the back part
  input  logic pay_busy,
  input  logic [$clog2(FRAME_BYTES)-1:0] pay_addr,
  output logic [7:0] pay_data
);
  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);

  logic [7:0] frame_buffer [FRAME_BYTES];
  logic [CW-1:0] received_count;
  logic [7:0] expected_length;
  logic receiving;
  logic [15:0] frame_timer;
  logic [15:0] running_crc;
  logic [7:0] b0, b1, b2, b3, b4, b5, b6;

  // one frame held for the back part at a time: stall intake while it is pending
  // or while its payload is still being copied out of the buffer
  assign in_ready = !hdr_valid && !pay_busy;

  logic [CW-1:0] cnt_base, cnt_new;
  logic [15:0] crc_base, crc_new;
  logic [7:0] fc_now, exp_new;
  logic [8:0] need;
  logic drop, done;

  always_comb begin
    cnt_base = receiving ? received_count : '0;
    crc_base = receiving ? running_crc : 16'hFFFF;
    cnt_new = cnt_base + 1'b1;
    crc_new = mbs_pkg::crc_byte(crc_base, rx_byte);
    fc_now = (cnt_base == CW'(1)) ? rx_byte : b1;
    need = 9'd9 + {1'b0, rx_byte};
    exp_new = receiving ? expected_length : mbs_pkg::UNKNOWN_LEN;
    drop = 1'b0;
    if (cnt_base >= CW'(FRAME_BYTES)) drop = 1'b1;
    else if (exp_new == mbs_pkg::UNKNOWN_LEN) begin
      if (cnt_new >= CW'(2) && (fc_now == mbs_pkg::FC_READ_HOLD ||
          fc_now == mbs_pkg::FC_READ_INPUT || fc_now == mbs_pkg::FC_WRITE_ONE))
        exp_new = 8'd8;
      else if (cnt_new >= CW'(7)) begin
        if (fc_now != mbs_pkg::FC_WRITE_MANY) drop = 1'b1;
        else if (need > 9'(FRAME_BYTES) || need >= 9'd254) drop = 1'b1;
        else exp_new = need[7:0];
      end
    end
    done = !drop && exp_new != mbs_pkg::UNKNOWN_LEN && {1'b0, cnt_new} >= (CW+1)'(exp_new);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      received_count <= '0;
      expected_length <= mbs_pkg::UNKNOWN_LEN;
      receiving <= 1'b0;
      frame_timer <= '0;
      running_crc <= 16'hFFFF;
      hdr_valid <= 1'b0;
    end else begin
      if (hdr_valid && hdr_ready) hdr_valid <= 1'b0;
      if (in_valid && in_ready) begin
        if (command) begin
          if (receiving) begin
            if (frame_timer != 16'hFFFF && frame_timer + 16'd1 >= timeout_ticks ||
                frame_timer == 16'hFFFF && frame_timer >= timeout_ticks) begin
              receiving <= 1'b0;
              frame_timer <= '0;
            end else if (frame_timer != 16'hFFFF) frame_timer <= frame_timer + 16'd1;
          end
        end else if (drop || done) begin
          receiving <= 1'b0;
          frame_timer <= '0;
          received_count <= '0;
          expected_length <= mbs_pkg::UNKNOWN_LEN;
          running_crc <= 16'hFFFF;
          if (done && crc_new == 16'h0000 && ((cnt_base == '0) ? rx_byte : b0) == device_address)
            hdr_valid <= 1'b1;
        end else begin
          if (!receiving) frame_timer <= '0;
          receiving <= 1'b1;
          received_count <= cnt_new;
          expected_length <= exp_new;
          running_crc <= crc_new;
        end
      end
    end
  end

  // header bytes captured as they arrive, payload kept in the buffer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && !command && cnt_base < CW'(FRAME_BYTES)) begin
      frame_buffer[cnt_base[AW-1:0]] <= rx_byte;
      case (cnt_base)
        CW'(0): b0 <= rx_byte;
        CW'(1): b1 <= rx_byte;
        CW'(2): b2 <= rx_byte;
        CW'(3): b3 <= rx_byte;
        CW'(4): b4 <= rx_byte;
        CW'(5): b5 <= rx_byte;
        CW'(6): b6 <= rx_byte;
        default: ;
      endcase
    end
    pay_data <= frame_buffer[pay_addr];
  end

  assign hdr = '{addr: b0, fc: b1, start: {b2, b3}, count: {b4, b5}, byte_count: b6};
endmodule

FILE: design/mbs_back.sv
module mbs_back #(
  parameter int FRAME_BYTES = 64,
  parameter int STORE_WORDS = 64,
  parameter int MAX_REGS_PER_REQUEST = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic hdr_valid,
  output logic hdr_ready,
  input  mbs_pkg::frame_hdr_t hdr,
  output logic pay_busy,
  output logic [$clog2(FRAME_BYTES)-1:0] pay_addr,
  input  logic [7:0] pay_data,
  input  logic [15:0] base_address,
  input  logic [6:0] window_size,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] tx_byte,
  output logic last
);
  localparam int AW = $clog2(FRAME_BYTES);
  localparam int SW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int NW = $clog2(MAX_REGS_PER_REQUEST + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_CHECK = 4'd1, S_HEAD = 4'd2, S_WRD = 4'd3,
                         S_WRW = 4'd4, S_RDA = 4'd5, S_RDW = 4'd6, S_RDH = 4'd7,
                         S_RDL = 4'd8, S_CRCL = 4'd9, S_CRCH = 4'd10, S_CLR = 4'd11,
                         S_WRH = 4'd12;

  logic [3:0] state;
  logic [15:0] store [STORE_WORDS];
  logic [SW-1:0] clr_idx;
  mbs_pkg::frame_hdr_t h;
  logic [2:0] hidx, hlen;
  logic [7:0] exc_code;
  logic is_exc;
  logic [SW-1:0] idx;
  logic [NW-1:0] i;
  logic [15:0] crc;
  logic [15:0] rd_word;
  logic [7:0] hi_byte;
  logic [7:0] win;
  logic [16:0] off;
  logic [17:0] endp;

  always_comb begin
    win = (32'(window_size) < STORE_WORDS) ? {1'b0, window_size} : 8'(STORE_WORDS);
    off = {1'b0, h.start} - {1'b0, base_address};
    endp = {1'b0, off} + ((h.fc == mbs_pkg::FC_WRITE_ONE) ? 18'd1 : {2'b0, h.count});
  end

  logic [7:0] head_b;
  always_comb begin
    case (hidx)
      3'd0: head_b = h.addr;
      3'd1: head_b = is_exc ? (h.fc | 8'h80) : h.fc;
      3'd2: head_b = is_exc ? exc_code :
                     (h.fc == mbs_pkg::FC_READ_HOLD || h.fc == mbs_pkg::FC_READ_INPUT) ?
                     8'(h.count[7:0] << 1) : h.start[15:8];
      3'd3: head_b = h.start[7:0];
      3'd4: head_b = h.count[15:8];
      default: head_b = h.count[7:0];
    endcase
  end

  logic [7:0] cur;
  always_comb begin
    unique case (state)
      S_HEAD: cur = head_b;
      S_RDH: cur = rd_word[15:8];
      S_RDL: cur = rd_word[7:0];
      S_CRCL: cur = crc[7:0];
      default: cur = crc[15:8];
    endcase
  end

  assign hdr_ready = (state == S_IDLE);
  // the frame buffer must not be refilled until the payload copy is over
  assign pay_busy = (state == S_CHECK || state == S_WRD || state == S_WRH || state == S_WRW);
  assign out_valid = (state == S_HEAD || state == S_RDH || state == S_RDL ||
                      state == S_CRCL || state == S_CRCH);
  assign tx_byte = cur;
  assign last = (state == S_CRCH);
  logic fire;
  assign fire = out_valid && out_ready;
  assign pay_addr = AW'(32'd7 + 32'(i) * 2 + ((state == S_WRH) ? 32'd1 : 32'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          store[clr_idx] <= '0;
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == STORE_WORDS - 1) state <= S_IDLE;
        end
        S_IDLE: if (hdr_valid) begin
          h <= hdr;
          state <= S_CHECK;
        end
        S_CHECK: begin
          hidx <= '0;
          crc <= 16'hFFFF;
          i <= '0;
          idx <= SW'(off);
          is_exc <= 1'b1;
          hlen <= 3'd3;
          exc_code <= mbs_pkg::EXC_ADDRESS;
          state <= S_HEAD;
          if (off[16] || endp > {10'd0, win}) begin
          end else if (h.fc == mbs_pkg::FC_WRITE_ONE) begin
            store[SW'(off)] <= h.count;
            is_exc <= 1'b0;
            hlen <= 3'd6;
          end else if (h.count == 16'd0 || h.count > 16'(MAX_REGS_PER_REQUEST)) begin
          end else if (h.fc == mbs_pkg::FC_WRITE_MANY) begin
            if ({9'd0, h.byte_count} != {h.count, 1'b0}) exc_code <= mbs_pkg::EXC_VALUE;
            else begin
              is_exc <= 1'b0;
              hlen <= 3'd6;
              state <= S_WRD;
            end
          end else begin
            is_exc <= 1'b0;
            hlen <= 3'd3;
          end
        end
        // payload copy: high byte then low byte per register
        S_WRD: state <= S_WRH;
        S_WRH: state <= S_WRW;
        S_WRW: begin
          store[idx] <= {hi_byte, pay_data};
          idx <= idx + 1'b1;
          i <= i + 1'b1;
          state <= ({1'b0, i} + 1'b1 == (NW+1)'(h.count)) ? S_HEAD : S_WRD;
        end
        S_HEAD: if (fire) begin
          crc <= mbs_pkg::crc_byte(crc, cur);
          hidx <= hidx + 1'b1;
          if (hidx + 1'b1 == hlen)
            state <= (!is_exc && (h.fc == mbs_pkg::FC_READ_HOLD ||
                      h.fc == mbs_pkg::FC_READ_INPUT)) ? S_RDA : S_CRCL;
        end
        S_RDA: state <= S_RDW;
        S_RDW: state <= S_RDH;
        S_RDH: if (fire) begin
          crc <= mbs_pkg::crc_byte(crc, cur);
          state <= S_RDL;
        end
        S_RDL: if (fire) begin
          crc <= mbs_pkg::crc_byte(crc, cur);
          idx <= idx + 1'b1;
          i <= i + 1'b1;
          state <= ({1'b0, i} + 1'b1 == (NW+1)'(h.count)) ? S_CRCL : S_RDA;
        end
        S_CRCL: if (fire) state <= S_CRCH;
        S_CRCH: if (fire) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RDA) rd_word <= store[idx];
    if (state == S_WRH) hi_byte <= pay_data;
  end
endmodule

FILE: design/modbus_rtu_register_slave_unit.sv
// Modbus RTU register slave. Feed received bytes (tuser 0) and timer ticks (tuser 1) on
// s_axis; the frame collector takes them while tready is high. A complete frame with good CRC
// and matching address is handed to the executor, which reads or writes the register window
// and streams the reply on m_axis, one byte per cycle when tready is high and no register is
// being fetched, tlast on the CRC high byte. The executor checks each frame, copies the payload
// of a multiple write high byte then low byte per register and fetches each register of a read
// before sending it. Intake stalls while a frame waits for the executor or is checked and while
// a multiple write copies its payload. The store is cleared after reset before any reply.
module modbus_rtu_register_slave_unit #(
  parameter int FRAME_BYTES = 64,
  parameter int STORE_WORDS = 64,
  parameter int MAX_REGS_PER_REQUEST = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // rx_byte
  input  logic s_axis_tuser,        // command
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [7:0] m_axis_tdata,  // tx_byte
  output logic m_axis_tlast,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  logic [7:0] device_address;
  logic [15:0] base_address;
  logic [6:0] window_size;
  logic [15:0] timeout_ticks;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd1;
      base_address <= 16'd0;
      window_size <= 7'd64;
      timeout_ticks <= 16'd500;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mbs_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data[7:0];
        mbs_pkg::CFG_BASE_ADDRESS: base_address <= cfg_data;
        mbs_pkg::CFG_WINDOW_SIZE: window_size <= cfg_data[6:0];
        mbs_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  logic hdr_valid, hdr_ready;
  mbs_pkg::frame_hdr_t hdr;
  logic pay_busy;
  logic [$clog2(FRAME_BYTES)-1:0] pay_addr;
  logic [7:0] pay_data;

  mbs_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .command(s_axis_tuser), .rx_byte(s_axis_tdata), .device_address, .timeout_ticks,
    .hdr_valid, .hdr_ready, .hdr, .pay_busy, .pay_addr, .pay_data
  );

  mbs_back #(.FRAME_BYTES(FRAME_BYTES), .STORE_WORDS(STORE_WORDS),
             .MAX_REGS_PER_REQUEST(MAX_REGS_PER_REQUEST)) u_back (
    .clk, .rst, .hdr_valid, .hdr_ready, .hdr, .pay_busy, .pay_addr, .pay_data,
    .base_address, .window_size, .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .tx_byte(m_axis_tdata), .last(m_axis_tlast)
  );
endmodule
